/* design/rpd_pkg.sv */
// ----------------------------------------------------------------------------
// rpd_pkg
// Shared types and constants for the RGB pixel run decoder.
// ----------------------------------------------------------------------------
package rpd_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned PHASE_W  = 3;
    localparam int unsigned IN_DATA_W  = 8;
    localparam int unsigned OUT_DATA_W = 32;

    localparam logic [BYTE_W-1:0] LIT_THRESHOLD = 8'd128;
    localparam logic [BYTE_W-1:0] RUN_BASE      = 8'd129;
    localparam logic [BYTE_W-1:0] LIT_BASE      = 8'd127;

    typedef enum logic [0:0] {
        MODE_BYTERUN = 1'b0,
        MODE_RLE     = 1'b1
    } run_mode_t;

    typedef enum logic [PHASE_W-1:0] {
        PH_CTRL  = 3'd0,
        PH_COUNT = 3'd1,
        PH_RED   = 3'd2,
        PH_GREEN = 3'd3,
        PH_BLUE  = 3'd4
    } phase_t;

    typedef struct packed {
        logic [BYTE_W-1:0] in_byte;
        logic              end_of_data;
    } in_item_t;

    typedef struct packed {
        logic [BYTE_W-1:0] repeat_count;
        logic [BYTE_W-1:0] blue;
        logic [BYTE_W-1:0] green;
        logic [BYTE_W-1:0] red;
    } result_t;

endpackage

/* design/rpd_in_stage.sv */
// ----------------------------------------------------------------------------
// rpd_in_stage
// Input register: holds one compressed byte until the decoder consumes it.
// ----------------------------------------------------------------------------
module rpd_in_stage (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [rpd_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    input  logic                             s_axis_tlast,
    input  logic                             consume,
    output logic                             item_valid,
    output rpd_pkg::in_item_t                item
);
    import rpd_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    in_item_t item_reg;

    assign s_axis_tready = !valid_reg || consume;
    assign valid_next    = s_axis_tvalid || (valid_reg && !consume);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            item_reg.in_byte     <= s_axis_tdata[BYTE_W-1:0];
            item_reg.end_of_data <= s_axis_tlast;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

/* design/rpd_decode.sv */
// ----------------------------------------------------------------------------
// rpd_decode
// Control-byte decoder: phase tracking, run/literal counts and triple assembly.
// ----------------------------------------------------------------------------
module rpd_decode (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_valid,
    input  logic                cfg_data,
    input  logic                consume,
    input  rpd_pkg::in_item_t   item,
    output logic                res_fire,
    output rpd_pkg::result_t    res
);
    import rpd_pkg::*;

    run_mode_t         mode_reg;
    phase_t            phase_reg,   phase_next;
    logic              lit_reg,     lit_next;
    logic [BYTE_W-1:0] left_reg,    left_next;
    logic [BYTE_W-1:0] repeat_reg,  repeat_next;
    logic [BYTE_W-1:0] red_reg,     red_next;
    logic [BYTE_W-1:0] green_reg,   green_next;
    logic [BYTE_W-1:0] b;
    logic              is_blue;

    assign b = item.in_byte;

    always_comb
    begin
        phase_next  = phase_reg;
        lit_next    = lit_reg;
        left_next   = left_reg;
        repeat_next = repeat_reg;
        red_next    = red_reg;
        green_next  = green_reg;
        is_blue     = 1'b0;
        case (phase_reg)
            PH_COUNT:
            begin
                if (b == '0)
                begin
                    phase_next = PH_CTRL;
                    lit_next   = 1'b0;
                    left_next  = '0;
                end
                else
                begin
                    phase_next  = PH_RED;
                    lit_next    = 1'b1;
                    left_next   = b;
                    repeat_next = 8'd1;
                end
            end
            PH_RED:
            begin
                red_next   = b;
                phase_next = PH_GREEN;
            end
            PH_GREEN:
            begin
                green_next = b;
                phase_next = PH_BLUE;
            end
            PH_BLUE:
            begin
                is_blue = 1'b1;
                if (lit_reg && (left_reg > 8'd1))
                begin
                    left_next  = left_reg - 8'd1;
                    phase_next = PH_RED;
                end
                else
                begin
                    left_next  = '0;
                    lit_next   = 1'b0;
                    phase_next = PH_CTRL;
                end
            end
            default:
            begin
                if (mode_reg == MODE_BYTERUN)
                begin
                    phase_next = PH_RED;
                    if (b < LIT_THRESHOLD)
                    begin
                        lit_next    = 1'b0;
                        left_next   = '0;
                        repeat_next = RUN_BASE - b;
                    end
                    else
                    begin
                        lit_next    = 1'b1;
                        left_next   = b - LIT_BASE;
                        repeat_next = 8'd1;
                    end
                end
                else
                begin
                    if (b == '0)
                    begin
                        phase_next = PH_COUNT;
                        lit_next   = 1'b1;
                        left_next  = '0;
                    end
                    else
                    begin
                        phase_next  = PH_RED;
                        lit_next    = 1'b0;
                        left_next   = '0;
                        repeat_next = b;
                    end
                end
            end
        endcase
        if (item.end_of_data)
        begin
            phase_next = PH_CTRL;
            lit_next   = 1'b0;
            left_next  = '0;
        end
    end

    assign res_fire         = consume && is_blue;
    assign res.red          = red_reg;
    assign res.green        = green_reg;
    assign res.blue         = b;
    assign res.repeat_count = lit_reg ? 8'd1 : repeat_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_BYTERUN;
            phase_reg  <= PH_CTRL;
            lit_reg    <= 1'b0;
            left_reg   <= '0;
            repeat_reg <= '0;
            red_reg    <= '0;
            green_reg  <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                mode_reg <= run_mode_t'(cfg_data);
            end
            if (consume)
            begin
                phase_reg  <= phase_next;
                lit_reg    <= lit_next;
                left_reg   <= left_next;
                repeat_reg <= repeat_next;
                red_reg    <= red_next;
                green_reg  <= green_next;
            end
        end
    end

endmodule

/* design/rpd_out_stage.sv */
// ----------------------------------------------------------------------------
// rpd_out_stage
// Result register: holds one decoded triple until the downstream takes it.
// ----------------------------------------------------------------------------
module rpd_out_stage (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             res_fire,
    input  rpd_pkg::result_t                 res,
    output logic                             out_free,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [rpd_pkg::OUT_DATA_W-1:0]   m_axis_tdata
);
    import rpd_pkg::*;

    logic    valid_reg;
    result_t res_reg;

    assign out_free = !valid_reg || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            valid_reg <= res_fire;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_fire)
        begin
            res_reg <= res;
        end
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = res_reg;

endmodule

/* design/rgb_pixel_run_decoder.sv */
// ----------------------------------------------------------------------------
// rgb_pixel_run_decoder
// Decodes ByteRun or zero-escaped RLE byte streams into RGB triples with
// repeat counts.
//
//   channel  | dir | handshake               | payload
//   s_axis   | in  | s_axis_tvalid/tready    | tdata in_byte, tlast end_of_data
//   m_axis   | out | m_axis_tvalid/tready    | tdata red, green, blue, repeat_count
//   cfg      | in  | cfg_valid/cfg_ready     | cfg_data run_mode
//
// One byte per clock sustained while m_axis takes results; a result becomes
// valid after its last byte passes the input register, then the result register.
// A result stalled at m_axis holds the decoder; s_axis_tready then drops
// once the input register is full.
// Reset clears the phase, counts, held colors and run_mode to ByteRun.
// ----------------------------------------------------------------------------
module rgb_pixel_run_decoder (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [rpd_pkg::IN_DATA_W-1:0]    s_axis_tdata,  // [7:0] in_byte
    input  logic                             s_axis_tlast,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [rpd_pkg::OUT_DATA_W-1:0]   m_axis_tdata,  // red, green, blue, repeat_count
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic                             cfg_data
);
    import rpd_pkg::*;

    logic     item_valid;
    in_item_t item;
    logic     out_free;
    logic     consume;
    logic     res_fire;
    result_t  res;

    assign consume   = item_valid && out_free;
    assign cfg_ready = 1'b1;

    rpd_in_stage u_in (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .consume       (consume),
        .item_valid    (item_valid),
        .item          (item)
    );

    rpd_decode u_dec (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .consume   (consume),
        .item      (item),
        .res_fire  (res_fire),
        .res       (res)
    );

    rpd_out_stage u_out (
        .clk           (clk),
        .rst_n         (rst_n),
        .res_fire      (res_fire),
        .res           (res),
        .out_free      (out_free),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule

/* design/rpd_checker.sv */
// ----------------------------------------------------------------------------
// rpd_checker
// Port-level checks for the RGB pixel run decoder.
// ----------------------------------------------------------------------------
module rpd_checker (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tready,
    input  logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    input  logic [rpd_pkg::OUT_DATA_W-1:0]   m_axis_tdata
);
    import rpd_pkg::*;

    result_t out_res;
    assign out_res = m_axis_tdata;

    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled result changed");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (out_res.repeat_count != '0))
        else $error("zero repeat count");

    assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output");

    assert property (@(posedge clk) disable iff (!rst_n)
        (!s_axis_tready) |-> (m_axis_tvalid && !m_axis_tready))
        else $error("input stalled without output backpressure");

endmodule

bind rgb_pixel_run_decoder rpd_checker u_rpd_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
